// ----- rtl/i2cmra_pkg.sv -----
`timescale 1ns / 1ps

package i2cmra_pkg;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_FALL = 4'd1,
    PH_START_LOW  = 4'd2,
    PH_TX_LOW     = 4'd3,
    PH_TX_HIGH    = 4'd4,
    PH_ACK_LOW    = 4'd5,
    PH_ACK_POLL   = 4'd6,
    PH_RX_LOW     = 4'd7,
    PH_RX_HIGH    = 4'd8,
    PH_MACK_LOW   = 4'd9,
    PH_MACK_HIGH  = 4'd10,
    PH_STOP_LOW   = 4'd11,
    PH_STOP_HIGH  = 4'd12,
    PH_STOP_RISE  = 4'd13,
    PH_RS_PREP    = 4'd14,
    PH_RS_HIGH    = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_DEV   = 2'd0,
    ROLE_REG   = 2'd1,
    ROLE_DEVRD = 2'd2,
    ROLE_DATA  = 2'd3
  } role_t;

  typedef enum logic [1:0] {
    OP_REG_WRITE = 2'd0,
    OP_REG_READ  = 2'd1,
    OP_TRANSMIT  = 2'd2,
    OP_RECEIVE   = 2'd3
  } op_t;

  localparam logic [7:0] ACK_WAIT_RESET = 8'd250;
  localparam logic [7:0] ACK_WAIT_SAT   = 8'd255;
  localparam logic [2:0] LAST_BIT       = 3'd7;

  typedef struct packed {
    logic       start_request;
    logic [1:0] operation;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic [7:0] read_data;
    logic       read_valid;
    logic       data_taken;
    logic       ack_missing;
    logic       busy_res;
    logic       done_res;
  } rsp_t;

endpackage

// ----- rtl/i2c_master_register_access_core.sv -----
`timescale 1ns / 1ps

// channel | direction | handshake          | word
// req     | in        | req_valid/req_stall | i2cmra_pkg::req_t, one bus phase tick
// rsp     | out       | rsp_valid/rsp_stall | i2cmra_pkg::rsp_t, line levels and flags
// cfg     | in        | cfg_valid/cfg_ready | ack_wait_limit, 8 bits
//
// One tick word is taken per clock while req_stall is low; its result word
// appears in the output register on the following cycle. The phase machine and
// the result register are the only timing stages. rst (synchronous) returns the
// bus to idle and ack_wait_limit to 250. req_stall is high only while a result
// waits under rsp_stall; the freed register takes a new word in the same cycle.

module i2c_master_register_access_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  i2cmra_pkg::req_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output i2cmra_pkg::rsp_t  rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  i2cmra_pkg::phase_t phase, phase_next;
  i2cmra_pkg::role_t  role, role_next;
  i2cmra_pkg::op_t    held_op, held_op_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] held_device, held_device_next;
  logic [7:0] held_register, held_register_next;
  logic [7:0] ack_count, ack_count_next;
  logic [7:0] ack_wait_limit;
  i2cmra_pkg::rsp_t res;
  logic accept;

  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= i2cmra_pkg::PH_IDLE;
      role           <= i2cmra_pkg::ROLE_DEV;
      held_op        <= i2cmra_pkg::OP_REG_WRITE;
      bit_index      <= '0;
      shift_byte     <= '0;
      bytes_left     <= '0;
      held_device    <= '0;
      held_register  <= '0;
      ack_count      <= '0;
      ack_wait_limit <= i2cmra_pkg::ACK_WAIT_RESET;
      rsp_valid      <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        role          <= role_next;
        held_op       <= held_op_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        bytes_left    <= bytes_left_next;
        held_device   <= held_device_next;
        held_register <= held_register_next;
        ack_count     <= ack_count_next;
      end
      if (cfg_valid) begin
        ack_wait_limit <= cfg_data;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= res;
    end
  end

  always_comb begin
    logic       proceed;
    logic       want_data;
    logic       want_read;
    logic [7:0] cnt_inc;

    phase_next         = phase;
    role_next          = role;
    held_op_next       = held_op;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    bytes_left_next    = bytes_left;
    held_device_next   = held_device;
    held_register_next = held_register;
    ack_count_next     = ack_count;

    proceed   = 1'b0;
    want_data = 1'b0;
    want_read = 1'b0;
    cnt_inc   = (ack_count < i2cmra_pkg::ACK_WAIT_SAT) ? ack_count + 8'd1 : ack_count;

    res                  = '0;
    res.scl_level        = 1'b1;
    res.sda_level        = 1'b1;
    res.sda_drive_enable = 1'b1;
    res.busy_res         = 1'b1;

    unique case (phase)
      i2cmra_pkg::PH_IDLE: begin
        res.busy_res = 1'b0;
        if (req.start_request) begin
          res.busy_res       = 1'b1;
          held_op_next       = i2cmra_pkg::op_t'(req.operation);
          held_device_next   = req.device_address;
          held_register_next = req.register_address;
          bytes_left_next    = req.byte_count;
          ack_count_next     = '0;
          bit_index_next     = '0;
          if (i2cmra_pkg::op_t'(req.operation) == i2cmra_pkg::OP_RECEIVE) begin
            shift_byte_next = req.device_address + 8'd1;
            role_next       = i2cmra_pkg::ROLE_DEVRD;
          end else begin
            shift_byte_next = req.device_address;
            role_next       = i2cmra_pkg::ROLE_DEV;
          end
          phase_next = i2cmra_pkg::PH_START_FALL;
        end
      end
      i2cmra_pkg::PH_START_FALL: begin
        res.sda_level = 1'b0;
        phase_next    = i2cmra_pkg::PH_START_LOW;
      end
      i2cmra_pkg::PH_START_LOW: begin
        res.scl_level  = 1'b0;
        res.sda_level  = 1'b0;
        bit_index_next = '0;
        phase_next     = i2cmra_pkg::PH_TX_LOW;
      end
      i2cmra_pkg::PH_TX_LOW: begin
        res.scl_level = 1'b0;
        res.sda_level = shift_byte[7];
        phase_next    = i2cmra_pkg::PH_TX_HIGH;
      end
      i2cmra_pkg::PH_TX_HIGH: begin
        res.sda_level   = shift_byte[7];
        shift_byte_next = {shift_byte[6:0], 1'b0};
        if (bit_index == i2cmra_pkg::LAST_BIT) begin
          bit_index_next = '0;
          ack_count_next = '0;
          phase_next     = i2cmra_pkg::PH_ACK_LOW;
        end else begin
          bit_index_next = bit_index + 3'd1;
          phase_next     = i2cmra_pkg::PH_TX_LOW;
        end
      end
      i2cmra_pkg::PH_ACK_LOW: begin
        res.scl_level        = 1'b0;
        res.sda_drive_enable = 1'b0;
        phase_next           = i2cmra_pkg::PH_ACK_POLL;
      end
      i2cmra_pkg::PH_ACK_POLL: begin
        res.sda_drive_enable = 1'b0;
        if (!req.sda_sample) begin
          proceed = 1'b1;
        end else begin
          ack_count_next = cnt_inc;
          if (cnt_inc >= ack_wait_limit) begin
            res.ack_missing = 1'b1;
            proceed         = 1'b1;
          end
        end
        if (proceed) begin
          ack_count_next = '0;
          case (role)
            i2cmra_pkg::ROLE_DEV: begin
              if (held_op == i2cmra_pkg::OP_REG_WRITE || held_op == i2cmra_pkg::OP_REG_READ) begin
                shift_byte_next = held_register;
                role_next       = i2cmra_pkg::ROLE_REG;
                bit_index_next  = '0;
                phase_next      = i2cmra_pkg::PH_TX_LOW;
              end else begin
                want_data = 1'b1;
              end
            end
            i2cmra_pkg::ROLE_REG: begin
              if (held_op == i2cmra_pkg::OP_REG_READ) begin
                role_next  = i2cmra_pkg::ROLE_DEVRD;
                phase_next = i2cmra_pkg::PH_RS_PREP;
              end else begin
                want_data = 1'b1;
              end
            end
            i2cmra_pkg::ROLE_DEVRD: want_read = 1'b1;
            default:                want_data = 1'b1;
          endcase
        end
      end
      i2cmra_pkg::PH_RS_PREP: begin
        res.scl_level = 1'b0;
        phase_next    = i2cmra_pkg::PH_RS_HIGH;
      end
      i2cmra_pkg::PH_RS_HIGH: begin
        shift_byte_next = held_device + 8'd1;
        role_next       = i2cmra_pkg::ROLE_DEVRD;
        bit_index_next  = '0;
        phase_next      = i2cmra_pkg::PH_START_FALL;
      end
      i2cmra_pkg::PH_RX_LOW: begin
        res.scl_level        = 1'b0;
        res.sda_drive_enable = 1'b0;
        phase_next           = i2cmra_pkg::PH_RX_HIGH;
      end
      i2cmra_pkg::PH_RX_HIGH: begin
        res.sda_drive_enable = 1'b0;
        shift_byte_next      = {shift_byte[6:0], req.sda_sample};
        if (bit_index == i2cmra_pkg::LAST_BIT) begin
          bit_index_next = '0;
          res.read_data  = {shift_byte[6:0], req.sda_sample};
          res.read_valid = 1'b1;
          phase_next     = i2cmra_pkg::PH_MACK_LOW;
        end else begin
          bit_index_next = bit_index + 3'd1;
          phase_next     = i2cmra_pkg::PH_RX_LOW;
        end
      end
      i2cmra_pkg::PH_MACK_LOW: begin
        // NACK once no bytes are left to read
        res.scl_level = 1'b0;
        res.sda_level = (bytes_left == '0);
        phase_next    = i2cmra_pkg::PH_MACK_HIGH;
      end
      i2cmra_pkg::PH_MACK_HIGH: begin
        res.sda_level = (bytes_left == '0);
        want_read     = 1'b1;
      end
      i2cmra_pkg::PH_STOP_LOW: begin
        res.scl_level = 1'b0;
        res.sda_level = 1'b0;
        phase_next    = i2cmra_pkg::PH_STOP_HIGH;
      end
      i2cmra_pkg::PH_STOP_HIGH: begin
        res.sda_level = 1'b0;
        phase_next    = i2cmra_pkg::PH_STOP_RISE;
      end
      i2cmra_pkg::PH_STOP_RISE: begin
        res.done_res = 1'b1;
        phase_next   = i2cmra_pkg::PH_IDLE;
      end
      default: begin
        res.busy_res = 1'b0;
        phase_next   = i2cmra_pkg::PH_IDLE;
      end
    endcase

    if (want_data) begin
      if (bytes_left == '0) begin
        phase_next = i2cmra_pkg::PH_STOP_LOW;
      end else begin
        bytes_left_next = bytes_left - 8'd1;
        shift_byte_next = req.write_data;
        role_next       = i2cmra_pkg::ROLE_DATA;
        bit_index_next  = '0;
        phase_next      = i2cmra_pkg::PH_TX_LOW;
        res.data_taken  = 1'b1;
      end
    end

    if (want_read) begin
      if (bytes_left == '0) begin
        phase_next = i2cmra_pkg::PH_STOP_LOW;
      end else begin
        bytes_left_next = bytes_left - 8'd1;
        shift_byte_next = '0;
        bit_index_next  = '0;
        phase_next      = i2cmra_pkg::PH_RX_LOW;
      end
    end

    // released line reads as high
    if (!res.sda_drive_enable) begin
      res.sda_level = 1'b1;
    end
  end

endmodule
